/* design/worst_fit_processor_assignment_top_defines.svh */
// Assertion macros used by the worst-fit allocator top level
`ifndef WORST_FIT_PROCESSOR_ASSIGNMENT_TOP_DEFINES_SVH
`define WORST_FIT_PROCESSOR_ASSIGNMENT_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define WFPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define WFPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/wfpa_pkg.sv */
// Types and constants of the worst-fit processor allocator
package wfpa_pkg;

    localparam int LoadW           = 16;
    localparam int UtilW           = 17;
    localparam int CfgW            = 4;
    localparam int IndexOutW       = 3;
    localparam int NumProcsDefault = 8;

    localparam logic [CfgW-1:0] ActiveReset = 4'd8;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_CLEARED = 2'd1,
        ST_TOO_BIG = 2'd2,
        ST_NO_FIT  = 2'd3
    } status_t;

    typedef enum logic {
        KIND_CLEAR = 1'b0,
        KIND_PLACE = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [UtilW-1:0]  task_util;
    } in_word_t;

    typedef struct packed {
        status_t               status;
        logic [IndexOutW-1:0]  proc_index;
        logic [LoadW-1:0]      new_load;
    } out_word_t;

endpackage

/* design/wfpa_select.sv */
// Worst-fit selection: least-loaded active processor that still fits, lowest index on a tie
module wfpa_select #(
    parameter  int NUM_PROCS = wfpa_pkg::NumProcsDefault,
    localparam int IdxW      = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1
) (
    input  logic [NUM_PROCS-1:0][wfpa_pkg::LoadW-1:0] loads,
    input  logic [wfpa_pkg::CfgW-1:0]                 active,
    input  logic [wfpa_pkg::LoadW-1:0]                util,
    output logic                                      found,
    output logic [IdxW-1:0]                           idx,
    output logic [wfpa_pkg::LoadW-1:0]                load
);
    import wfpa_pkg::*;

    localparam int Leaves = 1 << IdxW;
    localparam int Nodes  = 2 * Leaves - 1;
    localparam int CntW   = (IdxW + 1 > CfgW) ? IdxW + 1 : CfgW;

    logic [CntW-1:0]  active_ext;
    logic             node_ok   [Nodes];
    logic [LoadW-1:0] node_load [Nodes];
    logic [IdxW-1:0]  node_idx  [Nodes];
    logic [LoadW:0]   leaf_sum  [Leaves];

    assign active_ext = CntW'(active);

    always_comb
    begin
        // Qualify each leaf: active and load plus utilization stays below one
        for (int j = 0; j < Leaves; j++)
        begin
            node_idx[Leaves-1+j] = IdxW'(j);
            if (j < NUM_PROCS)
            begin
                leaf_sum[j]           = {1'b0, loads[j]} + {1'b0, util};
                node_load[Leaves-1+j] = loads[j];
                node_ok[Leaves-1+j]   = (CntW'(j) < active_ext) && !leaf_sum[j][LoadW];
            end
            else
            begin
                leaf_sum[j]           = '0;
                node_load[Leaves-1+j] = '0;
                node_ok[Leaves-1+j]   = 1'b0;
            end
        end

        // Reduce pairwise; the left child holds lower indices and wins ties
        for (int n = Leaves - 2; n >= 0; n--)
        begin
            if (node_ok[2*n+2] && (!node_ok[2*n+1] || node_load[2*n+2] < node_load[2*n+1]))
            begin
                node_ok[n]   = 1'b1;
                node_load[n] = node_load[2*n+2];
                node_idx[n]  = node_idx[2*n+2];
            end
            else
            begin
                node_ok[n]   = node_ok[2*n+1];
                node_load[n] = node_load[2*n+1];
                node_idx[n]  = node_idx[2*n+1];
            end
        end
    end

    assign found = node_ok[0];
    assign idx   = node_idx[0];
    assign load  = node_load[0];

endmodule

/* design/wfpa_loads.sv */
// Per-processor load registers with clear and single-entry update
module wfpa_loads #(
    parameter  int NUM_PROCS = wfpa_pkg::NumProcsDefault,
    localparam int IdxW      = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      clear,
    input  logic                                      update,
    input  logic [IdxW-1:0]                           upd_idx,
    input  logic [wfpa_pkg::LoadW-1:0]                upd_load,
    output logic [NUM_PROCS-1:0][wfpa_pkg::LoadW-1:0] loads
);
    import wfpa_pkg::*;

    logic [NUM_PROCS-1:0][LoadW-1:0] loads_reg;
    logic [NUM_PROCS-1:0][LoadW-1:0] loads_next;

    // Zero all on clear, otherwise write the chosen entry
    always_comb
    begin
        for (int i = 0; i < NUM_PROCS; i++)
        begin
            if (clear)
                loads_next[i] = '0;
            else if (update && upd_idx == IdxW'(i))
                loads_next[i] = upd_load;
            else
                loads_next[i] = loads_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            loads_reg <= '0;
        else
            loads_reg <= loads_next;
    end

    assign loads = loads_reg;

endmodule

/* design/worst_fit_processor_assignment_top.sv */
// Worst-fit task-to-processor allocator, top level
//
// Task channel: task_valid / task_stall / task_word. A word is a clear (zero
// every processor load) or a place request carrying a Q1.16 utilization.
// Result channel: result_valid / result_stall / result_word. Every task word
// gives exactly one result word: placed (index and new load), cleared,
// utilization too big, or no processor fits.
// Config: cfg_wr_en / cfg_wr_data write the active processor count at once.
//
// Flow: a word accepted at an edge is captured in the input register,
// is evaluated there and moves into the output register once that frees
// up, and appears on result_word from it. Throughput: one word per cycle
// while result_stall does not hold a pending result; the load update of
// one word is visible to the word right behind it, since the selection
// tree over NUM_PROCS load registers and the update close in the same cycle.
// Reset clears all loads to zero, sets the active count to 8 and empties
// both registers. While result_stall holds a pending result, the input
// register keeps its word and task_stall rises only once it is full.
`include "worst_fit_processor_assignment_top_defines.svh"

module worst_fit_processor_assignment_top #(
    parameter  int NUM_PROCS = wfpa_pkg::NumProcsDefault,
    localparam int IdxW      = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          task_valid,
    output logic                          task_stall,
    input  wfpa_pkg::in_word_t            task_word,
    output logic                          result_valid,
    input  logic                          result_stall,
    output wfpa_pkg::out_word_t           result_word,
    input  logic                          cfg_wr_en,
    input  logic [wfpa_pkg::CfgW-1:0]     cfg_wr_data
);
    import wfpa_pkg::*;

    logic [CfgW-1:0] active_reg;

    logic     in_valid_reg;
    logic     in_valid_next;
    in_word_t in_word_reg;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;
    out_word_t out_word_next;

    logic                            advance;
    logic                            fire;
    logic                            do_clear;
    logic                            do_place;
    logic                            sel_found;
    logic [IdxW-1:0]                 sel_idx;
    logic [LoadW-1:0]                sel_load;
    logic [LoadW-1:0]                placed_load;
    logic [IdxW+IndexOutW-1:0]       idx_wide;
    logic [NUM_PROCS-1:0][LoadW-1:0] loads;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= ActiveReset;
        else if (cfg_wr_en)
            active_reg <= cfg_wr_data;
    end

    // Handshake: the input register moves on when the output register frees up
    assign advance    = !out_valid_reg || !result_stall;
    assign task_stall = in_valid_reg && !advance;
    assign fire       = in_valid_reg && advance;

    assign in_valid_next = task_stall ? in_valid_reg : task_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Capture the incoming word
    always_ff @(posedge clk)
    begin
        if (task_valid && !task_stall)
            in_word_reg <= task_word;
    end

    wfpa_select #(
        .NUM_PROCS (NUM_PROCS)
    ) u_select (
        .loads  (loads),
        .active (active_reg),
        .util   (in_word_reg.task_util[LoadW-1:0]),
        .found  (sel_found),
        .idx    (sel_idx),
        .load   (sel_load)
    );

    // Decide the outcome of the word in the input register
    assign placed_load = sel_load + in_word_reg.task_util[LoadW-1:0];
    assign idx_wide    = {{IndexOutW{1'b0}}, sel_idx};
    assign do_clear    = fire && in_word_reg.kind == KIND_CLEAR;
    assign do_place    = fire && in_word_reg.kind == KIND_PLACE
                         && !in_word_reg.task_util[LoadW] && sel_found;

    always_comb
    begin
        out_word_next.proc_index = '0;
        out_word_next.new_load   = '0;
        if (in_word_reg.kind == KIND_CLEAR)
            out_word_next.status = ST_CLEARED;
        else if (in_word_reg.task_util[LoadW])
            out_word_next.status = ST_TOO_BIG;
        else if (sel_found)
        begin
            out_word_next.status     = ST_PLACED;
            out_word_next.proc_index = idx_wide[IndexOutW-1:0];
            out_word_next.new_load   = placed_load;
        end
        else
            out_word_next.status = ST_NO_FIT;
    end

    wfpa_loads #(
        .NUM_PROCS (NUM_PROCS)
    ) u_loads (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (do_clear),
        .update   (do_place),
        .upd_idx  (sel_idx),
        .upd_load (placed_load),
        .loads    (loads)
    );

    // Output register: hold while stalled, load on fire
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_word_reg <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    // Checks
    `WFPA_ASSERT_NOW(a_stall_only_when_full, task_stall, in_valid_reg, "stall with empty input register")
    `WFPA_ASSERT_NEXT(a_fire_gives_result, fire, result_valid, "evaluated word produced no result")
    `WFPA_ASSERT_NEXT(a_clear_zeroes_loads, do_clear, loads == '0, "loads not zero after clear")
    `WFPA_ASSERT_NOW(a_place_fits, do_place, placed_load >= sel_load, "placed load overflowed")

endmodule
